FILE: rtl/core/lrc_pkg.sv
package lrc_pkg;

	localparam int CW  = 16;      // endpoint coordinate width
	localparam int WW  = 20;      // working coordinate width, holds edges and clipped values
	localparam int DVW = 17;      // divisor width, one plus a span
	localparam int NW  = 31;      // dividend and quotient width
	localparam int SW  = 32;      // signed slope width
	localparam int PW  = WW + SW; // clip product width
	localparam int FW  = 4;       // fraction bit count width
	localparam int AW  = 3;       // config index width
	localparam int QD  = 4;       // queue depth
	localparam int QAW = 2;       // queue pointer width

	localparam logic [AW-1:0] REG_LEFT   = 3'd0;
	localparam logic [AW-1:0] REG_TOP    = 3'd1;
	localparam logic [AW-1:0] REG_WIDTH  = 3'd2;
	localparam logic [AW-1:0] REG_HEIGHT = 3'd3;
	localparam logic [AW-1:0] REG_FRAC   = 3'd4;

	localparam logic [FW-1:0] FRAC_RST = 4'd8;

	typedef struct packed {
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] top;
		logic [CW-2:0]        width;
		logic [CW-2:0]        height;
		logic [FW-1:0]        frac;
	} cfg_t;

	// segment ordered by X (a has the smaller X), ord set when a is the second endpoint
	typedef struct packed {
		logic                 ord;
		logic                 xmiss;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [SW-1:0] slope_x;
		logic signed [SW-1:0] slope_y;
	} item_t;

	typedef struct packed {
		logic [CW-1:0] csy;
		logic [CW-1:0] csx;
		logic [CW-1:0] cfy;
		logic [CW-1:0] cfx;
		logic          hit;
	} res_t;

endpackage

FILE: rtl/core/lrc_div.sv
module lrc_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lrc_pkg::NW-1:0]      num,
	input  logic [lrc_pkg::DVW-1:0]     den,
	output logic [lrc_pkg::NW-1:0]      quo
);

	// one quotient bit per stage, remainder kept below the divisor
	logic [lrc_pkg::DVW-1:0] r_q [lrc_pkg::NW];
	logic [lrc_pkg::NW-1:0]  n_q [lrc_pkg::NW];
	logic [lrc_pkg::DVW-1:0] d_q [lrc_pkg::NW];

	function automatic logic [lrc_pkg::DVW+lrc_pkg::NW-1:0] step(
		input logic [lrc_pkg::DVW-1:0] r,
		input logic [lrc_pkg::NW-1:0]  n,
		input logic [lrc_pkg::DVW-1:0] d
	);
		logic [lrc_pkg::DVW:0]   t;
		logic                    ge;
		logic [lrc_pkg::DVW-1:0] r_n;
		t   = {r, n[lrc_pkg::NW-1]};
		ge  = t >= {1'b0, d};
		r_n = ge ? lrc_pkg::DVW'(t - {1'b0, d}) : t[lrc_pkg::DVW-1:0];
		return {r_n, n[lrc_pkg::NW-2:0], ge};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			{r_q[0], n_q[0]} <= step('0, num, den);
			d_q[0] <= den;
			for (int k = 1; k < lrc_pkg::NW; k++) begin
				{r_q[k], n_q[k]} <= step(r_q[k-1], n_q[k-1], d_q[k-1]);
				d_q[k] <= d_q[k-1];
			end
		end
	end

	assign quo = n_q[lrc_pkg::NW-1];

endmodule

FILE: rtl/core/lrc_front.sv
module lrc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrc_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lrc_pkg::item_t       out_item
);

	typedef struct packed {
		logic                          ord;
		logic                          xmiss;
		logic                          dyneg;
		logic signed [lrc_pkg::CW-1:0] ax;
		logic signed [lrc_pkg::CW-1:0] ay;
		logic signed [lrc_pkg::CW-1:0] bx;
		logic signed [lrc_pkg::CW-1:0] by;
	} side_t;

	logic en;

	logic signed [lrc_pkg::CW-1:0] x0, y0, x1, y1;
	logic                          sw;
	side_t                         side;
	logic signed [lrc_pkg::CW:0]   dx, dy;
	logic [lrc_pkg::CW:0]          ady;
	logic signed [lrc_pkg::WW-1:0] ex1, ex2;

	assign x0 = signed'(in_data[15:0]);
	assign y0 = signed'(in_data[31:16]);
	assign x1 = signed'(in_data[47:32]);
	assign y1 = signed'(in_data[63:48]);
	assign sw = x1 < x0;

	assign ex1 = lrc_pkg::WW'(cfg.left);
	assign ex2 = lrc_pkg::WW'(cfg.left) + signed'(lrc_pkg::WW'(cfg.width));

	always_comb begin
		side.ord = sw;
		side.ax  = sw ? x1 : x0;
		side.ay  = sw ? y1 : y0;
		side.bx  = sw ? x0 : x1;
		side.by  = sw ? y0 : y1;
		dx = (lrc_pkg::CW+1)'(side.bx) - (lrc_pkg::CW+1)'(side.ax);
		dy = (lrc_pkg::CW+1)'(side.by) - (lrc_pkg::CW+1)'(side.ay);
		ady = dy[lrc_pkg::CW] ? unsigned'(-dy) : unsigned'(dy);
		side.dyneg = dy[lrc_pkg::CW];
		side.xmiss = (lrc_pkg::WW'(side.ax) >= ex2) || (lrc_pkg::WW'(side.bx) <= ex1);
	end

	logic                        v_s1;
	side_t                       side_s1;
	logic [lrc_pkg::NW-1:0]      nx_s1, ny_s1;
	logic [lrc_pkg::DVW-1:0]     dvx_s1, dvy_s1;
	logic                        v_q [lrc_pkg::NW];
	side_t                       side_q [lrc_pkg::NW];
	logic [lrc_pkg::NW-1:0]      qx, qy;

	assign out_valid = v_q[lrc_pkg::NW-1];
	assign en        = !(out_valid && !out_ready);
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < lrc_pkg::NW; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_q[0] <= v_s1;
			for (int k = 1; k < lrc_pkg::NW; k++) v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side;
			nx_s1     <= lrc_pkg::NW'(ady) << cfg.frac;
			ny_s1     <= lrc_pkg::NW'(unsigned'(dx)) << cfg.frac;
			dvx_s1    <= lrc_pkg::DVW'(unsigned'(dx)) + lrc_pkg::DVW'(1);
			dvy_s1    <= lrc_pkg::DVW'(ady) + lrc_pkg::DVW'(1);
			side_q[0] <= side_s1;
			for (int k = 1; k < lrc_pkg::NW; k++) side_q[k] <= side_q[k-1];
		end
	end

	lrc_div u_div_x (.clk(clk), .en(en), .num(nx_s1), .den(dvx_s1), .quo(qx));
	lrc_div u_div_y (.clk(clk), .en(en), .num(ny_s1), .den(dvy_s1), .quo(qy));

	logic signed [lrc_pkg::SW-1:0] sqx;
	side_t                         so;

	assign sqx = signed'(lrc_pkg::SW'(qx));
	assign so  = side_q[lrc_pkg::NW-1];

	always_comb begin
		out_item.ord     = so.ord;
		out_item.xmiss   = so.xmiss;
		out_item.ax      = so.ax;
		out_item.ay      = so.ay;
		out_item.bx      = so.bx;
		out_item.by      = so.by;
		out_item.slope_x = so.dyneg ? -sqx : sqx;
		out_item.slope_y = signed'(lrc_pkg::SW'(qy));
	end

endmodule

FILE: rtl/core/lrc_queue.sv
module lrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lrc_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output lrc_pkg::item_t  out_item
);

	lrc_pkg::item_t         mem_q [lrc_pkg::QD];
	logic [lrc_pkg::QAW-1:0] wr_q, rd_q;
	logic [lrc_pkg::QAW:0]   cnt_q;
	logic                    push, pop;

	assign in_ready  = cnt_q != (lrc_pkg::QAW+1)'(lrc_pkg::QD);
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (lrc_pkg::QAW+1)'(push) - (lrc_pkg::QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

endmodule

FILE: rtl/core/lrc_back.sv
module lrc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lrc_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  lrc_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output lrc_pkg::res_t   out_res
);

	typedef logic signed [lrc_pkg::WW-1:0] wc_t;
	typedef logic signed [lrc_pkg::PW-1:0] prod_t;

	typedef struct packed {
		logic                          ord;
		logic                          xmiss;
		logic                          ymiss;
		logic                          ca;
		logic                          cb;
		wc_t                           ax;
		wc_t                           ay;
		wc_t                           bx;
		wc_t                           by;
		logic signed [lrc_pkg::SW-1:0] slope;
	} st_t;

	logic  en;
	wc_t   x1, x2, y1, y2;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	st_t   st_s1, st_s2, st_s3, st_s4;
	logic signed [lrc_pkg::SW-1:0] sy_s1;
	prod_t pa_s1, pb_s1, pa_s4, pb_s4;
	lrc_pkg::res_t res_s5;

	assign x1 = lrc_pkg::WW'(cfg.left);
	assign x2 = lrc_pkg::WW'(cfg.left) + signed'(lrc_pkg::WW'(cfg.width));
	assign y1 = lrc_pkg::WW'(cfg.top);
	assign y2 = lrc_pkg::WW'(cfg.top) + signed'(lrc_pkg::WW'(cfg.height));

	assign out_valid = v_s5;
	assign out_res   = res_s5;
	assign en        = !(v_s5 && !out_ready);
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= {in_valid, v_s1, v_s2, v_s3, v_s4};
		end
	end

	// compare the ends against the left and right bounds
	st_t s1_n;
	always_comb begin
		s1_n.ord   = in_item.ord;
		s1_n.xmiss = in_item.xmiss;
		s1_n.ymiss = 1'b0;
		s1_n.ax    = lrc_pkg::WW'(in_item.ax);
		s1_n.ay    = lrc_pkg::WW'(in_item.ay);
		s1_n.bx    = lrc_pkg::WW'(in_item.bx);
		s1_n.by    = lrc_pkg::WW'(in_item.by);
		s1_n.ca    = s1_n.ax < x1;
		s1_n.cb    = s1_n.bx > x2;
		s1_n.slope = in_item.slope_x;
	end

	// X clip applied
	st_t s2_n;
	always_comb begin
		s2_n    = st_s1;
		if (st_s1.ca) begin
			s2_n.ay = st_s1.ay + lrc_pkg::WW'(pa_s1 >>> cfg.frac);
			s2_n.ax = x1;
		end
		if (st_s1.cb) begin
			s2_n.by = st_s1.by - lrc_pkg::WW'(pb_s1 >>> cfg.frac);
			s2_n.bx = x2;
		end
		s2_n.slope = sy_s1;
	end

	// reorder by Y
	st_t  s3_n;
	logic ysw;
	always_comb begin
		ysw        = st_s2.by < st_s2.ay;
		s3_n       = st_s2;
		s3_n.ord   = st_s2.ord ^ ysw;
		s3_n.ax    = ysw ? st_s2.bx : st_s2.ax;
		s3_n.ay    = ysw ? st_s2.by : st_s2.ay;
		s3_n.bx    = ysw ? st_s2.ax : st_s2.bx;
		s3_n.by    = ysw ? st_s2.ay : st_s2.by;
		s3_n.slope = ysw ? -st_s2.slope : st_s2.slope;
		s3_n.ymiss = (s3_n.ay >= y2) || (s3_n.by <= y1);
		s3_n.ca    = s3_n.ay < y1;
		s3_n.cb    = s3_n.by > y2;
	end

	// Y clip applied, back to input order
	st_t           s5;
	lrc_pkg::res_t res_n;
	logic          hit;
	always_comb begin
		s5 = st_s4;
		if (st_s4.ca) begin
			s5.ax = st_s4.ax + lrc_pkg::WW'(pa_s4 >>> cfg.frac);
			s5.ay = y1;
		end
		if (st_s4.cb) begin
			s5.bx = st_s4.bx - lrc_pkg::WW'(pb_s4 >>> cfg.frac);
			s5.by = y2;
		end
		hit       = !st_s4.xmiss && !st_s4.ymiss;
		res_n.hit = hit;
		res_n.cfx = '0;
		res_n.cfy = '0;
		res_n.csx = '0;
		res_n.csy = '0;
		if (hit) begin
			res_n.cfx = s5.ord ? s5.bx[lrc_pkg::CW-1:0] : s5.ax[lrc_pkg::CW-1:0];
			res_n.cfy = s5.ord ? s5.by[lrc_pkg::CW-1:0] : s5.ay[lrc_pkg::CW-1:0];
			res_n.csx = s5.ord ? s5.ax[lrc_pkg::CW-1:0] : s5.bx[lrc_pkg::CW-1:0];
			res_n.csy = s5.ord ? s5.ay[lrc_pkg::CW-1:0] : s5.by[lrc_pkg::CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= s1_n;
			sy_s1  <= in_item.slope_y;
			pa_s1  <= prod_t'(x1 - s1_n.ax) * prod_t'(in_item.slope_x);
			pb_s1  <= prod_t'(s1_n.bx - x2) * prod_t'(in_item.slope_x);
			st_s2  <= s2_n;
			st_s3  <= s3_n;
			st_s4  <= st_s3;
			pa_s4  <= prod_t'(y1 - st_s3.ay) * prod_t'(st_s3.slope);
			pb_s4  <= prod_t'(st_s3.by - y2) * prod_t'(st_s3.slope);
			res_s5 <= res_n;
		end
	end

endmodule

FILE: rtl/core/line_rect_clipper_top.sv
// Clips one line segment per transfer against the rectangle set by the config registers and
// returns a hit flag with the clipped endpoints in input order, all zero on a miss. A new
// segment is taken every cycle unless a full queue stalls the front end, which has a set-up
// register and two 31-stage dividers for the slopes, one quotient bit per stage; after it
// come a four-entry queue and the clip stages, ending in the output register. Config must
// only be written while no segment is in flight.
module line_rect_clipper_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [lrc_pkg::AW-1:0]  cfg_addr,
	input  logic [15:0]             cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [63:0]             s_tdata,  // first_x, first_y, second_x, second_y
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [71:0]             m_tdata   // hit, clipped_first_x, clipped_first_y,
	                                          // clipped_second_x, clipped_second_y, zero pad
);

	lrc_pkg::cfg_t  cfg_q;
	lrc_pkg::item_t f_item, q_item;
	lrc_pkg::res_t  res;
	logic           f_valid, f_ready, q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= '0;
			cfg_q.top    <= '0;
			cfg_q.width  <= '0;
			cfg_q.height <= '0;
			cfg_q.frac   <= lrc_pkg::FRAC_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lrc_pkg::REG_LEFT:   cfg_q.left   <= signed'(cfg_wdata);
				lrc_pkg::REG_TOP:    cfg_q.top    <= signed'(cfg_wdata);
				lrc_pkg::REG_WIDTH:  cfg_q.width  <= cfg_wdata[14:0];
				lrc_pkg::REG_HEIGHT: cfg_q.height <= cfg_wdata[14:0];
				lrc_pkg::REG_FRAC:   cfg_q.frac   <= cfg_wdata[lrc_pkg::FW-1:0];
				default: ;
			endcase
		end
	end

	lrc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	lrc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	lrc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {7'b0, res};

endmodule

FILE: rtl/core/lrc_checker.sv
module lrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0)
		else $error("miss with non-zero coordinates");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == 7'd0)
		else $error("pad bits set");

	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight out of reset");

endmodule

bind line_rect_clipper_top lrc_checker u_lrc_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: test/tb_top.sv
module tb_top;

	typedef struct {
		logic        hit;
		logic [15:0] fx, fy, sx, sy;
	} clip_res_t;

	class clip_scoreboard;
		clip_res_t pending[$];
		longint    left, top, width, height;
		int        frac;
		int        errors;

		function new();
			left = 0;
			top = 0;
			width = 0;
			height = 0;
			frac = 8;
			errors = 0;
		endfunction

		function longint floor_shift(longint v, int s);
			if (v >= 0)
				return v >>> s;
			return -(((-v) - 1) >>> s) - 1;
		endfunction

		function void write_reg(logic [lrc_pkg::AW-1:0] idx, logic [15:0] v);
			case (idx)
				lrc_pkg::REG_LEFT:   left = longint'($signed(v));
				lrc_pkg::REG_TOP:    top = longint'($signed(v));
				lrc_pkg::REG_WIDTH:  width = longint'(v[14:0]);
				lrc_pkg::REG_HEIGHT: height = longint'(v[14:0]);
				lrc_pkg::REG_FRAC:   frac = int'(v[3:0]);
				default: ;
			endcase
		endfunction

		function void note_segment(logic [63:0] d);
			longint px[2], py[2];
			longint x1, x2, y1, y2, sc, dx, dy, ady, slx, sly;
			int a, b, t;
			clip_res_t r;
			x1 = left;
			x2 = left + width;
			y1 = top;
			y2 = top + height;
			sc = longint'(1) << frac;
			a = 0;
			b = 1;
			px[0] = longint'($signed(d[15:0]));
			py[0] = longint'($signed(d[31:16]));
			px[1] = longint'($signed(d[47:32]));
			py[1] = longint'($signed(d[63:48]));
			r = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0};
			if (px[b] < px[a]) begin
				a = 1;
				b = 0;
			end
			if (!(px[a] >= x2 || px[b] <= x1)) begin
				dx = px[b] - px[a];
				dy = py[b] - py[a];
				ady = dy < 0 ? -dy : dy;
				slx = (dy * sc) / (1 + dx);
				sly = (dx * sc) / (1 + ady);
				if (px[a] < x1) begin
					py[a] = py[a] + floor_shift((x1 - px[a]) * slx, frac);
					px[a] = x1;
				end
				if (px[b] > x2) begin
					py[b] = py[b] - floor_shift((px[b] - x2) * slx, frac);
					px[b] = x2;
				end
				if (py[b] < py[a]) begin
					t = a;
					a = b;
					b = t;
					sly = -sly;
				end
				if (!(py[a] >= y2 || py[b] <= y1)) begin
					if (py[a] < y1) begin
						px[a] = px[a] + floor_shift((y1 - py[a]) * sly, frac);
						py[a] = y1;
					end
					if (py[b] > y2) begin
						px[b] = px[b] - floor_shift((py[b] - y2) * sly, frac);
						py[b] = y2;
					end
					r.hit = 1'b1;
					r.fx = px[0][15:0];
					r.fy = py[0][15:0];
					r.sx = px[1][15:0];
					r.sy = py[1][15:0];
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [71:0] d);
			clip_res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.hit || d[16:1] !== e.fx || d[32:17] !== e.fy ||
			    d[48:33] !== e.sx || d[64:49] !== e.sy) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp hit %b %h %h %h %h, got hit %b %h %h %h %h",
						e.hit, e.fx, e.fy, e.sx, e.sy,
						d[0], d[16:1], d[32:17], d[48:33], d[64:49]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [lrc_pkg::AW-1:0] cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	clip_scoreboard sb;
	bit          quiet;

	line_rect_clipper_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// output side: random stall bursts, steady in the quiet part
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 6);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);

	task automatic write_reg(logic [lrc_pkg::AW-1:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic set_rect(logic [15:0] l, logic [15:0] t, logic [14:0] w, logic [14:0] h,
		logic [3:0] f);
		write_reg(lrc_pkg::REG_LEFT, l);
		write_reg(lrc_pkg::REG_TOP, t);
		write_reg(lrc_pkg::REG_WIDTH, {1'b0, w});
		write_reg(lrc_pkg::REG_HEIGHT, {1'b0, h});
		write_reg(lrc_pkg::REG_FRAC, {12'd0, f});
		cfg_we <= 1'b0;
	endtask

	task automatic send(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1, logic [15:0] y1);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y1, x1, y0, x0};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_segment(s_tdata);
	endtask

	task automatic drain();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [15:0] near(logic [15:0] c, int span);
		return c + 16'($urandom_range(0, 2 * span)) - 16'(span);
	endfunction

	task automatic random_phase(int count);
		logic [15:0] l, t;
		int span;
		for (int i = 0; i < count; i++) begin
			l = sb.left[15:0];
			t = sb.top[15:0];
			span = int'(sb.width + sb.height) + 64;
			if ($urandom_range(0, 4) == 0)
				send(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else
				send(near(l, span), near(t, span), near(l, span), near(t, span));
		end
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: zero-size rectangle at the origin
		send(16'hFFF6, 16'hFFF6, 16'd10, 16'd10);
		send(16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		set_rect(16'd10, 16'd20, 15'd100, 15'd50, 4'd8);
		send(16'd0, 16'd30, 16'd200, 16'd60);      // left and right clip
		send(16'd200, 16'd60, 16'd0, 16'd30);      // same, swapped order
		send(16'd50, 16'd0, 16'd60, 16'd100);      // top and bottom clip
		send(16'd60, 16'd100, 16'd50, 16'd0);
		send(16'd20, 16'd30, 16'd40, 16'd40);      // fully inside
		send(16'd0, 16'd0, 16'd5, 16'd100);        // miss left
		send(16'd200, 16'd0, 16'd300, 16'd100);    // miss right
		send(16'd20, 16'd0, 16'd40, 16'd5);        // miss above
		send(16'd10, 16'd30, 16'd110, 16'd30);     // on edges
		send(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send(16'h8000, 16'd40, 16'h7FFF, 16'd40);
		send(16'd50, 16'h8000, 16'd50, 16'h7FFF);
		drain();

		// wide right/bottom edges beyond the 16-bit range, extreme frac
		set_rect(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 4'd15);
		send(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send(16'h7FF0, 16'h7FF0, 16'h7FFF, 16'h7FFF);
		drain();
		set_rect(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 4'd0);
		send(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send(16'hFFFF, 16'h1234, 16'h0001, 16'hEDCB);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			set_rect(16'($urandom), 16'($urandom), 15'($urandom_range(0, 2000)),
				15'($urandom_range(0, 2000)), 4'($urandom_range(0, 15)));
			random_phase(100);
			drain();
		end
		set_rect(16'hFF00, 16'h0100, 15'd300, 15'd300, 4'd15);
		random_phase(80);
		drain();
		quiet = 1'b1;
		set_rect(16'd0, 16'd0, 15'd500, 15'd200, 4'd4);
		random_phase(100);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
